[hdl/true_strength_index_assert.svh]
// Assertion macros for the true strength index block.
// Used by the port checker; expects clk and arst_n in the enclosing scope.
`ifndef TRUE_STRENGTH_INDEX_ASSERT_SVH
`define TRUE_STRENGTH_INDEX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("true_strength_index: assertion failed");

// Next-cycle implication, disabled during reset.
`define TSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("true_strength_index: assertion failed");

`endif

[hdl/tsi_pkg.sv]
// Shared types and constants for the true strength index block.
// No dependencies.
package tsi_pkg;

	// default parameter values
	localparam int PRICE_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// result format
	localparam int TSI_W    = 15;
	localparam int TSI_FULL = 10000;

	// configuration registers
	localparam int   CFG_DATA_W       = 11;
	localparam logic CFG_LONG_IDX     = 1'b0;
	localparam logic CFG_SHORT_IDX    = 1'b1;
	localparam int   LONG_PERIOD_RST  = 25;
	localparam int   SHORT_PERIOD_RST = 13;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[hdl/tsi_div.sv]
// Restoring divider, one quotient bit per cycle, for the true strength index block.
// Depends on tsi_pkg (div_sts_t).
module tsi_div import tsi_pkg::*; #(
	parameter int NUM_W = 62,
	parameter int DEN_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_sts_t         sts,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;

	// trial subtract of the divisor from the shifted remainder
	assign trial  = {rem_q, quo_q[NUM_W-1]};
	assign ge     = trial >= {1'b0, den_q};
	assign rem_nx = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	// control: step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q;

endmodule

[hdl/true_strength_index.sv]
// True strength index: four EMAs on one shared multiplier, ratio from a serial divider.
// From an accepted item to out_valid: a priming item goes straight to the output; others run
// four EMA updates and the ratio product, then the divider unless the denominator is zero.
// One item at a time: the next input is taken only after the result is loaded for output.
// A configuration write recomputes alpha in the divider; input is stalled until it finishes.
// Reset (arst_n low, async): averages, last price, primed cleared; periods back to 25 and 13.
module true_strength_index import tsi_pkg::*; #(
	parameter int PRICE_BITS    = PRICE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PRICE_BITS-1:0]   close_price,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [TSI_W-1:0] tsi_value,
	output logic                    was_first_sample,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int P     = PRICE_BITS;
	localparam int F     = FRACTION_BITS;
	localparam int NW    = P + F;          // magnitude of an average
	localparam int MW    = P + F + 1;      // magnitude of an EMA difference
	localparam int AW    = P + F + 2;      // signed average
	localparam int DW    = P + F + 14;     // ratio dividend
	localparam int AL_W  = F + 1;
	localparam int AN_W  = (F + 2 > 12) ? F + 2 : 12;
	localparam int MA_W  = (F + 1 > 14) ? F + 1 : 14;
	localparam int MB_W  = (P + 1 > F) ? P + 1 : F;
	localparam int PR_W  = MA_W + MB_W;
	localparam int HALF  = 1 << (F - 1);
	localparam int ONE2  = 1 << (F + 1);
	localparam logic [AL_W-1:0] ALPHA_L_RST =
		AL_W'((ONE2 + (LONG_PERIOD_RST + 1) / 2) / (LONG_PERIOD_RST + 1));
	localparam logic [AL_W-1:0] ALPHA_S_RST =
		AL_W'((ONE2 + (SHORT_PERIOD_RST + 1) / 2) / (SHORT_PERIOD_RST + 1));

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CFG     = 4'd1;
	localparam logic [3:0] S_EMA_D   = 4'd2;
	localparam logic [3:0] S_EMA_LO  = 4'd3;
	localparam logic [3:0] S_EMA_HI  = 4'd4;
	localparam logic [3:0] S_EMA_ADD = 4'd5;
	localparam logic [3:0] S_T_LO    = 4'd6;
	localparam logic [3:0] S_T_HI    = 4'd7;
	localparam logic [3:0] S_T_SUM   = 4'd8;
	localparam logic [3:0] S_T_DIV   = 4'd9;
	localparam logic [3:0] S_OUT     = 4'd10;

	logic [3:0]             state_q;
	logic                   primed_q;
	logic [P-1:0]           last_q;
	logic [P-1:0]           price_q;
	logic signed [AW-1:0]   avg_q [4];   // m long, |m| long, m short, |m| short
	logic [1:0]             e_q;
	logic                   dneg_q;
	logic [MW-1:0]          mag_q;
	logic [PR_W-1:0]        prod_q;
	logic [F+1:0]           tmp_q;
	logic [PR_W-1:0]        plo_q;
	logic [AL_W-1:0]        alpha_l_q;
	logic [AL_W-1:0]        alpha_s_q;
	logic                   cfg_sel_q;
	logic signed [TSI_W-1:0] res_q;
	logic                   first_q;
	logic                   out_valid_q;

	logic                   in_acc;
	logic                   cfg_acc;
	logic                   out_load;
	logic signed [P+1:0]    diff;
	logic signed [AW-1:0]   m_val;
	logic signed [AW-1:0]   am_val;
	logic signed [AW-1:0]   x_sel;
	logic signed [AW-1:0]   ema_cur;
	logic signed [AW-1:0]   d_val;
	logic [MW-1:0]          d_mag;
	logic [AL_W-1:0]        alpha_cur;
	logic [MA_W-1:0]        mul_a;
	logic [MB_W-1:0]        mul_b;
	logic [PR_W-1:0]        mul_p;
	logic [PR_W:0]          rnd_sum;
	logic signed [AW-1:0]   step_val;
	logic signed [AW-1:0]   ema_new;
	logic [NW-1:0]          num_mag;
	logic [NW-1:0]          den_val;
	logic                   den_pos;
	logic                   tsi_neg;
	logic [CFG_DATA_W-1:0]  per_fix;
	logic [CFG_DATA_W:0]    per_p1;
	logic [AN_W-1:0]        alpha_num;
	logic [DW-1:0]          div_num_tsi;
	logic [DW-1:0]          div_num;
	logic [NW-1:0]          div_den;
	logic                   div_start;
	div_sts_t               div_sts;
	logic [DW-1:0]          div_quot;
	logic                   q_sat;
	logic [TSI_W-1:0]       q_mag;
	logic signed [TSI_W-1:0] q_res;

	// handshakes; configuration yields to a waiting input transaction
	assign in_stall  = (state_q != S_IDLE) || div_sts.busy;
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// momentum scaled to the fraction format
	assign diff   = $signed({2'b00, price_q}) - $signed({2'b00, last_q});
	assign m_val  = {diff, {F{1'b0}}};
	assign am_val = m_val[AW-1] ? -m_val : m_val;

	// EMA operand selection
	always_comb begin
		unique case (e_q)
			2'd0: x_sel = m_val;
			2'd1: x_sel = am_val;
			2'd2: x_sel = avg_q[0];
			2'd3: x_sel = avg_q[1];
		endcase
	end
	assign ema_cur   = avg_q[e_q];
	assign alpha_cur = e_q[1] ? alpha_s_q : alpha_l_q;
	assign d_val     = x_sel - ema_cur;
	assign d_mag     = MW'(d_val[AW-1] ? -d_val : d_val);

	// ratio operands
	assign tsi_neg = avg_q[2][AW-1];
	assign num_mag = NW'(tsi_neg ? -avg_q[2] : avg_q[2]);
	assign den_val = avg_q[3][NW-1:0];
	assign den_pos = !avg_q[3][AW-1] && (avg_q[3] != '0);

	// shared multiplier, low and high halves of the operand in turn
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_EMA_LO: begin
				mul_a = MA_W'(alpha_cur);
				mul_b = MB_W'(mag_q[F-1:0]);
			end
			S_EMA_HI: begin
				mul_a = MA_W'(alpha_cur);
				mul_b = MB_W'(mag_q[MW-1:F]);
			end
			S_T_LO: begin
				mul_a = MA_W'(TSI_FULL);
				mul_b = MB_W'(num_mag[F-1:0]);
			end
			S_T_HI: begin
				mul_a = MA_W'(TSI_FULL);
				mul_b = MB_W'(num_mag[NW-1:F]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PR_W'(mul_a) * PR_W'(mul_b);

	// rounded step, sign of the difference applied afterwards
	assign rnd_sum  = {1'b0, prod_q} + (PR_W + 1)'(HALF);
	assign step_val = AW'(prod_q) + AW'(tmp_q);
	assign ema_new  = dneg_q ? ema_cur - step_val : ema_cur + step_val;

	// alpha = (2^(F+1) + (p+1)/2) / (p+1), zero period taken as one
	assign per_fix   = (cfg_data == '0) ? CFG_DATA_W'(1) : cfg_data;
	assign per_p1    = {1'b0, per_fix} + 1'b1;
	assign alpha_num = AN_W'(ONE2) + AN_W'(per_p1 >> 1);

	// divider requests: alpha on a configuration write, ratio after the averages
	assign div_num_tsi = (DW'(prod_q) << F) + DW'(plo_q) + DW'(den_val >> 1);
	assign div_start   = cfg_acc || (state_q == S_T_SUM);
	assign div_num     = (state_q == S_T_SUM) ? div_num_tsi : DW'(alpha_num);
	assign div_den     = (state_q == S_T_SUM) ? den_val : NW'(per_p1);

	tsi_div #(
		.NUM_W (DW),
		.DEN_W (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	// saturate and sign the quotient
	assign q_sat = div_quot > DW'(TSI_FULL);
	assign q_mag = q_sat ? TSI_W'(TSI_FULL) : div_quot[TSI_W-1:0];
	assign q_res = tsi_neg ? -q_mag : q_mag;

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			primed_q  <= 1'b0;
			last_q    <= '0;
			e_q       <= '0;
			cfg_sel_q <= CFG_LONG_IDX;
			alpha_l_q <= ALPHA_L_RST;
			alpha_s_q <= ALPHA_S_RST;
			for (int i = 0; i < 4; i++) begin
				avg_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!primed_q) begin
							primed_q <= 1'b1;
							last_q   <= close_price;
							state_q  <= S_OUT;
						end else begin
							e_q     <= '0;
							state_q <= S_EMA_D;
						end
					end else if (cfg_acc) begin
						cfg_sel_q <= cfg_index;
						state_q   <= S_CFG;
					end
				end
				S_CFG: begin
					if (div_sts.done) begin
						if (cfg_sel_q == CFG_LONG_IDX) begin
							alpha_l_q <= AL_W'(div_quot);
						end else begin
							alpha_s_q <= AL_W'(div_quot);
						end
						state_q <= S_IDLE;
					end
				end
				S_EMA_D:  state_q <= S_EMA_LO;
				S_EMA_LO: state_q <= S_EMA_HI;
				S_EMA_HI: state_q <= S_EMA_ADD;
				S_EMA_ADD: begin
					avg_q[e_q] <= ema_new;
					e_q        <= e_q + 1'b1;
					state_q    <= (e_q == 2'd3) ? S_T_LO : S_EMA_D;
				end
				S_T_LO: begin
					last_q  <= price_q;
					state_q <= den_pos ? S_T_HI : S_OUT;
				end
				S_T_HI:  state_q <= S_T_SUM;
				S_T_SUM: state_q <= S_T_DIV;
				S_T_DIV: begin
					if (div_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_acc) begin
			price_q <= close_price;
			res_q   <= '0;
			first_q <= !primed_q;
		end
		if (state_q == S_EMA_D) begin
			dneg_q <= d_val[AW-1];
			mag_q  <= d_mag;
		end
		if (state_q == S_EMA_HI) begin
			tmp_q <= (F + 2)'(rnd_sum >> F);
		end
		if (state_q == S_T_HI) begin
			plo_q <= prod_q;
		end
		if ((state_q == S_T_DIV) && div_sts.done) begin
			res_q <= q_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tsi_value        <= res_q;
			was_first_sample <= first_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/tsi_check.sv]
// Port-level checker for the true strength index block, bound to its top level.
// Depends on tsi_pkg and true_strength_index_assert.svh.
`include "true_strength_index_assert.svh"

module tsi_check import tsi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [TSI_W-1:0] tsi_value,
	input logic                    was_first_sample,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	// a held result keeps its value
	`TSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tsi_value) && $stable(was_first_sample))

	// results stay within the saturation limits
	`TSI_ASSERT_NOW(a_out_range, out_valid, (tsi_value <= TSI_W'(TSI_FULL)) && (tsi_value >= -TSI_W'(TSI_FULL)))

	// a priming transaction answers zero
	`TSI_ASSERT_NOW(a_first_zero, out_valid && was_first_sample, tsi_value == '0)

	// an accepted item occupies the block
	`TSI_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

	// a configuration write starts the alpha recompute
	`TSI_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready, !cfg_ready && in_stall)

endmodule

bind true_strength_index tsi_check u_tsi_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.tsi_value        (tsi_value),
	.was_first_sample (was_first_sample),
	.cfg_valid        (cfg_valid),
	.cfg_ready        (cfg_ready)
);

[test/true_strength_index_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for true_strength_index: directed and random-walk closing prices,
// each result checked against a bit-exact TSI predictor. Needs tsi_pkg and the block's RTL.
module true_strength_index_test;
	import tsi_pkg::*;

	localparam int FRAC_BITS      = FRACTION_BITS_DEF;
	localparam int PRICE_W        = PRICE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 300;
	localparam int DRAIN_CYCLES   = 120;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 241;

	typedef struct packed {
		logic signed [TSI_W-1:0] tsi;
		logic                    first;
	} tsi_result_t;

	// block ports
	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic [PRICE_W-1:0]      close_price = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic signed [TSI_W-1:0] tsi_value;
	logic                    was_first_sample;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic                    cfg_index   = CFG_LONG_IDX;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;

	// stimulus and scoreboard
	logic [PRICE_W-1:0] price_queue[$];
	tsi_result_t        tsi_expected_q[$];
	int                 items_queued   = 0;
	int                 result_count   = 0;
	int                 error_count    = 0;
	int                 send_gap_max   = 0;
	int                 recv_stall_max = 0;
	int                 send_wait      = 0;
	int                 recv_wait      = 0;
	int                 wait_left;
	int                 idle_cycles    = 0;
	logic               hold_on        = 1'b0;
	tsi_result_t        want;

	// predictor state
	logic [CFG_DATA_W-1:0] pred_long_per  = CFG_DATA_W'(LONG_PERIOD_RST);
	logic [CFG_DATA_W-1:0] pred_short_per = CFG_DATA_W'(SHORT_PERIOD_RST);
	logic                  primed       = 1'b0;
	logic [PRICE_W-1:0]    last_price   = '0;
	longint                mom_avg_long = 0;
	longint                abs_avg_long = 0;
	longint                mom_avg_dbl  = 0;
	longint                abs_avg_dbl  = 0;

	// directed price runs
	logic [PRICE_W-1:0] opening_prices[11] = '{32'd1000, 32'd1000, 32'd1000, 32'hFFFF_FFFF,
		32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd6, 32'd4};
	logic [PRICE_W-1:0] fast_prices[6] = '{32'd100, 32'd200, 32'd50, 32'd50,
		32'hFFFF_FFFF, 32'd0};
	logic [PRICE_W-1:0] slow_prices[5] = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
		32'h8000_0000};

	// periods for the random walk phases
	logic [CFG_DATA_W-1:0] long_set[RANDOM_PHASES]  = '{11'd1, 11'd1024, 11'd1, 11'd1024,
		11'd25, 11'd0, 11'd0, 11'd3};
	logic [CFG_DATA_W-1:0] short_set[RANDOM_PHASES] = '{11'd1, 11'd1024, 11'd1024, 11'd1,
		11'd13, 11'd0, 11'd0, 11'd2};

	true_strength_index DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.close_price      (close_price),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tsi_value        (tsi_value),
		.was_first_sample (was_first_sample),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// smoothing factor 2/(p+1) in Q1.16, period 0 acts as 1
	function automatic logic [63:0] alpha_for(input logic [CFG_DATA_W-1:0] period);
		logic [63:0] p;
		p = (period == 0) ? 64'd1 : 64'(period);
		return ((64'd1 << (FRAC_BITS + 1)) + ((p + 64'd1) >> 1)) / (p + 64'd1);
	endfunction

	// one EMA update, step magnitude rounded half away from zero
	function automatic longint ema_next(input longint avg, input longint x,
		input logic [63:0] alpha);
		longint      diff;
		logic [63:0] mag, hi, lo, incr;
		diff = x - avg;
		mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
		hi   = mag >> FRAC_BITS;
		lo   = mag & ((64'd1 << FRAC_BITS) - 64'd1);
		incr = alpha * hi + ((alpha * lo + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		return (diff < 0) ? avg - longint'(incr) : avg + longint'(incr);
	endfunction

	// advances the predictor by one closing price, returns the expected result
	function automatic tsi_result_t predict_tsi(input logic [PRICE_W-1:0] price);
		tsi_result_t r;
		longint      mom, abs_mom;
		logic [63:0] a_long, a_short, num, den, q;
		logic        neg;
		r.tsi   = '0;
		r.first = 1'b0;
		if (!primed) begin
			primed     = 1'b1;
			last_price = price;
			r.first    = 1'b1;
			return r;
		end
		mom     = ($signed({32'd0, price}) - $signed({32'd0, last_price}))
			* (longint'(1) << FRAC_BITS);
		abs_mom = (mom < 0) ? -mom : mom;
		a_long  = alpha_for(pred_long_per);
		a_short = alpha_for(pred_short_per);
		mom_avg_long = ema_next(mom_avg_long, mom, a_long);
		abs_avg_long = ema_next(abs_avg_long, abs_mom, a_long);
		mom_avg_dbl  = ema_next(mom_avg_dbl, mom_avg_long, a_short);
		abs_avg_dbl  = ema_next(abs_avg_dbl, abs_avg_long, a_short);
		last_price   = price;
		// zero denominator leaves the index at 0
		if (abs_avg_dbl > 0) begin
			den = 64'(abs_avg_dbl);
			neg = mom_avg_dbl < 0;
			num = neg ? 64'(-mom_avg_dbl) : 64'(mom_avg_dbl);
			q   = (num * 64'(TSI_FULL) + (den >> 1)) / den;
			if (q > 64'(TSI_FULL))
				q = 64'(TSI_FULL);
			r.tsi = TSI_W'(neg ? -q : q);
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		if (error_count < 10)
			$display("%s", msg);
		error_count++;
	endtask

	// one register write; the accepting edge is sampled before it updates the block
	task automatic write_period(input logic idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk iff cfg_ready);
		if (idx == CFG_LONG_IDX)
			pred_long_per = value;
		else
			pred_short_per = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// every queued price has produced its result
	task automatic wait_for_drain();
		while (result_count != items_queued)
			@(posedge clk);
	endtask

	// driver: presents queued prices, random gap after each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			close_price <= '0;
			send_wait   <= 0;
		end else begin
			if (in_valid && !in_stall)
				tsi_expected_q.push_back(predict_tsi(close_price));
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					in_valid  <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (price_queue.size() != 0) begin
					in_valid    <= 1'b1;
					close_price <= price_queue.pop_front();
					send_wait   <= $urandom_range(0, send_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction, then stalls for a drawn count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			wait_left = recv_wait;
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (tsi_expected_q.size() == 0) begin
					flag_error($sformatf("unexpected result: tsi=%0d first=%0b",
						tsi_value, was_first_sample));
				end else begin
					want = tsi_expected_q.pop_front();
					if (want.tsi !== tsi_value || want.first !== was_first_sample)
						flag_error($sformatf(
							"result %0d: expected tsi=%0d first=%0b, got tsi=%0d first=%0b",
							result_count, $signed(want.tsi), want.first,
							tsi_value, was_first_sample));
				end
				wait_left = $urandom_range(0, recv_stall_max);
			end else if (out_valid && wait_left != 0) begin
				wait_left = wait_left - 1;
			end
			out_stall <= hold_on || (wait_left != 0);
			recv_wait <= wait_left;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (result_count >= HOLD_AFTER);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_on <= 1'b0;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// stimulus sequence
	initial begin
		int                    phase;
		int                    n;
		logic [PRICE_W-1:0]    level;
		logic [31:0]           span;
		logic [CFG_DATA_W-1:0] lp, sp;

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset periods: priming, flat bars, full-scale swings
		foreach (opening_prices[i]) begin
			price_queue.push_back(opening_prices[i]);
			items_queued++;
		end
		wait_for_drain();

		// zero period, alpha of one: index follows the sign of each move
		write_period(CFG_LONG_IDX, 11'd0);
		write_period(CFG_SHORT_IDX, 11'd0);
		send_gap_max   = 18;
		recv_stall_max = 18;
		foreach (fast_prices[i]) begin
			price_queue.push_back(fast_prices[i]);
			items_queued++;
		end
		wait_for_drain();

		// largest period the register holds
		write_period(CFG_LONG_IDX, 11'd2047);
		write_period(CFG_SHORT_IDX, 11'd2047);
		foreach (slow_prices[i]) begin
			price_queue.push_back(slow_prices[i]);
			items_queued++;
		end
		wait_for_drain();

		// random walk phases over a spread of periods and idling mixes
		level = 32'h8000_0000;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			lp = long_set[phase];
			sp = short_set[phase];
			if (phase == 5) begin
				lp = CFG_DATA_W'($urandom_range(1, 1024));
				sp = CFG_DATA_W'($urandom_range(1, 1024));
			end else if (phase == 6) begin
				lp = CFG_DATA_W'($urandom_range(0, 2047));
				sp = CFG_DATA_W'($urandom_range(0, 2047));
			end
			write_period(CFG_LONG_IDX, lp);
			write_period(CFG_SHORT_IDX, sp);
			send_gap_max   = (phase % 2 != 0) ? 18 : 0;
			recv_stall_max = (phase % 3 == 1) ? 0 : 18;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0, 1: level = $urandom();
					2: ;   // flat bar
					default: begin
						span  = 32'd1 << $urandom_range(0, 24);
						level = level + $urandom_range(0, span) - (span >> 1);
					end
				endcase
				price_queue.push_back(level);
				items_queued++;
			end
			wait_for_drain();
		end

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0 && tsi_expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/tsi_pkg.sv
hdl/tsi_div.sv
hdl/true_strength_index.sv
hdl/tsi_check.sv
test/true_strength_index_test.sv
